// ----- hdl/prld_pkg.sv -----
// Package for the packed run-length decoder: opcode constants, phase and
// class codes, result kinds and end status codes. No dependencies.
package prld_pkg;

	localparam logic [7:0] BLANK_BYTE    = 8'h40;
	localparam logic [7:0] OP_SHORT_MAX  = 8'h77;
	localparam logic [7:0] OP_COPY_MIN   = 8'h80;
	localparam logic [7:0] OP_COPY_MAX   = 8'hF7;
	localparam logic [7:0] OP_COPY_BIAS  = 8'h7F;
	localparam logic [7:0] OP_HDR_COPY   = 8'hF8;
	localparam logic [7:0] OP_END_CLEAN  = 8'hFF;
	localparam logic [7:0] OP_BAD_A      = 8'hFA;
	localparam logic [7:0] OP_BAD_B      = 8'hFB;
	localparam logic [7:0] OP_BAD_C      = 8'hFE;
	localparam logic [31:0] CEILING_RESET = 32'h1000_0000;

	typedef enum logic [4:0] {
		PH_OPCODE   = 5'b00001,
		PH_COUNT_HI = 5'b00010,
		PH_COUNT_LO = 5'b00100,
		PH_RUN_BYTE = 5'b01000,
		PH_COPY     = 5'b10000
	} phase_t;

	typedef enum logic [1:0] {
		CL_NONE  = 2'd0,
		CL_BLANK = 2'd1,
		CL_BYTE  = 2'd2,
		CL_COPY  = 2'd3
	} op_class_t;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_RUN  = 2'd1,
		KIND_LIT  = 2'd2
	} item_kind_t;

	typedef enum logic [2:0] {
		ST_NONE      = 3'd0,
		ST_CLEAN     = 3'd1,
		ST_MALFORMED = 3'd2,
		ST_EXHAUSTED = 3'd3,
		ST_OVERFLOW  = 3'd4
	} end_status_t;

endpackage

// ----- hdl/prld_stream_if.sv -----
// Input channel of the packed run-length decoder: one packed byte per item
// with first and last marks. Depends on nothing.
interface prld_stream_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output first_byte, output last_byte,
		input ready);
	modport sink (input valid, input data_byte, input first_byte, input last_byte,
		output ready);
endinterface

// ----- hdl/prld_result_if.sv -----
// Result channel of the packed run-length decoder: run descriptors, literal
// bytes and end notices. Depends on prld_pkg.
interface prld_result_if;
	import prld_pkg::*;

	logic        valid;
	logic        ready;
	item_kind_t  item_kind;
	logic [7:0]  out_byte;
	logic [16:0] run_length;
	logic [31:0] total_out;
	logic        end_flag;
	end_status_t end_status;

	modport source (output valid, output item_kind, output out_byte, output run_length,
		output total_out, output end_flag, output end_status, input ready);
	modport sink (input valid, input item_kind, input out_byte, input run_length,
		input total_out, input end_flag, input end_status, output ready);
endinterface

// ----- hdl/pack_run_length_decoder.sv -----
// Top level of the packed run-length decoder: input register, phase machine,
// overflow check and result register. Depends on prld_pkg and both interfaces.

// The decoder takes one packed byte per item on stream and returns at most one
// item on result: a run descriptor (byte, length), a literal byte, or an
// end-only notice. It accepts a byte in every cycle when result is not stalled;
// each byte is held in the input register and, once the result register is
// free, its item is loaded there, so throughput is one byte per cycle. The
// rate is set by the single phase-machine update per byte, whose longest path is
// the 33-bit add and compare of the running total against output_ceiling.
// Opcodes 0x00-0x77 give a blank run, 0x80-0xF7 a literal copy, 0x78-0x7F and
// 0xF8/0xF9/0xFC/0xFD take a one- or two-byte count (plus a run byte for the
// 0x7A/0x7B class); 0xFF ends cleanly, 0xFA/0xFB/0xFE end as malformed. A last
// mark ends the stream as exhausted; a run or copy past the ceiling ends it as
// overflow with an end-only notice. After an end, bytes are dropped without result
// until one carries the first mark. Write the ceiling only while idle.
module pack_run_length_decoder (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          ceiling_we,
	input  logic [31:0]   ceiling_wdata,
	prld_stream_if.sink   stream,
	prld_result_if.source result
);
	import prld_pkg::*;

	// Input register
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        first_s1;
	logic        last_s1;

	// Decoder state
	logic [31:0] ceiling_q;
	phase_t      phase_q;
	op_class_t   class_q;
	logic [16:0] pend_q;
	logic [7:0]  hi_q;
	logic [31:0] total_q;
	logic        done_q;

	// Result register
	logic        out_valid_q;
	item_kind_t  kind_q;
	logic [7:0]  byte_q;
	logic [16:0] len_q;
	logic [31:0] tot_out_q;
	end_status_t status_q;

	// Handshake
	logic out_free;
	logic advance;

	// State as seen by the byte in the input register (first mark clears it)
	phase_t      ph;
	op_class_t   cls;
	logic [16:0] pend;
	logic [7:0]  hi;
	logic [31:0] tot;
	logic        done;

	// Length check
	logic [16:0] count_len;
	logic [16:0] op_len;
	logic [16:0] fit_len;
	logic [32:0] sum;
	logic        fits;

	// Next state and result
	phase_t      ph_n;
	op_class_t   cls_n;
	logic [16:0] pend_n;
	logic [7:0]  hi_n;
	logic [31:0] tot_n;
	logic        done_n;
	logic        emit;
	item_kind_t  kind_n;
	logic [7:0]  byte_n;
	logic [16:0] len_n;
	end_status_t status_n;
	logic        do_run;
	logic [7:0]  run_val;
	logic        do_copy;

	assign out_free     = !out_valid_q || result.ready;
	assign advance      = valid_s1 && out_free;
	assign stream.ready = !valid_s1 || out_free;

	assign ph   = first_s1 ? PH_OPCODE : phase_q;
	assign cls  = first_s1 ? CL_NONE : class_q;
	assign pend = first_s1 ? 17'd0 : pend_q;
	assign hi   = first_s1 ? 8'd0 : hi_q;
	assign tot  = first_s1 ? 32'd0 : total_q;
	assign done = first_s1 ? 1'b0 : done_q;

	// One shared add and compare: the only length checked is the one this byte
	// completes (short run or copy opcode, count, or pending run length).
	assign count_len = {1'b0, hi, data_s1} + 17'd1;
	assign op_len    = (data_s1 <= OP_SHORT_MAX) ? {9'd0, data_s1} + 17'd1
		: {9'd0, data_s1 - OP_COPY_BIAS};
	assign fit_len   = (ph == PH_RUN_BYTE) ? pend
		: (ph == PH_COUNT_LO) ? count_len : op_len;
	assign sum       = {1'b0, tot} + {16'd0, fit_len};
	assign fits      = sum <= {1'b0, ceiling_q};

	always_comb begin
		ph_n     = ph;
		cls_n    = cls;
		pend_n   = pend;
		hi_n     = hi;
		tot_n    = tot;
		emit     = 1'b0;
		kind_n   = KIND_NONE;
		byte_n   = 8'd0;
		len_n    = 17'd0;
		status_n = ST_NONE;
		do_run   = 1'b0;
		run_val  = BLANK_BYTE;
		do_copy  = 1'b0;

		if (!done) begin
			unique case (ph)
				PH_COUNT_HI: begin
					hi_n = data_s1;
					ph_n = PH_COUNT_LO;
					if (last_s1) begin
						emit     = 1'b1;
						status_n = ST_EXHAUSTED;
					end
				end
				PH_COUNT_LO: begin
					pend_n = count_len;
					if (cls == CL_BLANK) begin
						do_run = 1'b1;
					end else if (cls == CL_COPY) begin
						do_copy = 1'b1;
					end else begin
						ph_n = PH_RUN_BYTE;
						if (last_s1) begin
							emit     = 1'b1;
							status_n = ST_EXHAUSTED;
						end
					end
				end
				PH_RUN_BYTE: begin
					do_run  = 1'b1;
					run_val = data_s1;
				end
				PH_COPY: begin
					tot_n  = tot + 32'd1;
					pend_n = pend - 17'd1;
					if (pend_n == 17'd0) begin
						ph_n = PH_OPCODE;
					end
					emit     = 1'b1;
					kind_n   = KIND_LIT;
					byte_n   = data_s1;
					len_n    = 17'd1;
					status_n = last_s1 ? ST_EXHAUSTED : ST_NONE;
				end
				default: begin
					ph_n = PH_OPCODE;
					if (data_s1 <= OP_SHORT_MAX) begin
						do_run = 1'b1;
					end else if (data_s1 >= OP_COPY_MIN && data_s1 <= OP_COPY_MAX) begin
						do_copy = 1'b1;
					end else if (data_s1 == OP_END_CLEAN) begin
						emit     = 1'b1;
						status_n = ST_CLEAN;
					end else if (data_s1 == OP_BAD_A || data_s1 == OP_BAD_B
						|| data_s1 == OP_BAD_C) begin
						emit     = 1'b1;
						status_n = ST_MALFORMED;
					end else begin
						// Count header: class from the high range and bit 1, width from bit 0
						if (data_s1 >= OP_HDR_COPY) begin
							cls_n = CL_COPY;
						end else if (data_s1[1]) begin
							cls_n = CL_BYTE;
						end else begin
							cls_n = CL_BLANK;
						end
						hi_n = 8'd0;
						ph_n = data_s1[0] ? PH_COUNT_HI : PH_COUNT_LO;
						if (last_s1) begin
							emit     = 1'b1;
							status_n = ST_EXHAUSTED;
						end
					end
				end
			endcase

			if (do_run) begin
				emit = 1'b1;
				if (!fits) begin
					status_n = ST_OVERFLOW;
				end else begin
					tot_n    = sum[31:0];
					ph_n     = PH_OPCODE;
					kind_n   = KIND_RUN;
					byte_n   = run_val;
					len_n    = fit_len;
					status_n = last_s1 ? ST_EXHAUSTED : ST_NONE;
				end
			end

			if (do_copy) begin
				if (!fits) begin
					emit     = 1'b1;
					status_n = ST_OVERFLOW;
				end else begin
					pend_n = fit_len;
					ph_n   = PH_COPY;
					if (last_s1) begin
						emit     = 1'b1;
						status_n = ST_EXHAUSTED;
					end
				end
			end
		end

		done_n = done || (emit && status_n != ST_NONE);
	end

	// Capture the next item; drop the held one once it is processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.valid && stream.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			data_s1  <= stream.data_byte;
			first_s1 <= stream.first_byte;
			last_s1  <= stream.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceiling_q <= CEILING_RESET;
		end else if (ceiling_we) begin
			ceiling_q <= ceiling_wdata;
		end
	end

	// Advance the phase machine once per processed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OPCODE;
			class_q <= CL_NONE;
			pend_q  <= 17'd0;
			hi_q    <= 8'd0;
			total_q <= 32'd0;
			done_q  <= 1'b0;
		end else if (advance) begin
			phase_q <= ph_n;
			class_q <= cls_n;
			pend_q  <= pend_n;
			hi_q    <= hi_n;
			total_q <= tot_n;
			done_q  <= done_n;
		end
	end

	// Hold the result until taken; load a new one only when the slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			kind_q    <= kind_n;
			byte_q    <= byte_n;
			len_q     <= len_n;
			tot_out_q <= tot_n;
			status_q  <= status_n;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.item_kind  = kind_q;
	assign result.out_byte   = byte_q;
	assign result.run_length = len_q;
	assign result.total_out  = tot_out_q;
	assign result.end_flag   = (status_q != ST_NONE);
	assign result.end_status = status_q;

	// An empty input register always takes a byte.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> stream.ready)
		else $error("input refused while input register empty");

	// An end-only notice must actually end the stream.
	a_none_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == KIND_NONE) |-> status_q != ST_NONE)
		else $error("end-only item without end status");

	// Literals carry length one; runs carry a nonzero length.
	a_lengths: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == KIND_LIT) |-> len_q == 17'd1)
		else $error("literal with length other than one");

	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == KIND_RUN) |-> len_q != 17'd0)
		else $error("run with zero length");

	// After a stream ends, nothing is emitted until a first mark arrives.
	a_quiet_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && done_q && !first_s1) |=> !$rose(out_valid_q))
		else $error("result emitted after stream end");

endmodule

// ----- bench/pack_run_length_decoder_tb.sv -----
// Self-checking bench for pack_run_length_decoder: drives packed streams and
// checks every result item against a decoder model kept inside the bench.
// Depends on prld_pkg, prld_stream_if, prld_result_if and the decoder itself.
module pack_run_length_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import prld_pkg::*;

	// Header opcodes that the package does not name; OP_ALIAS turns each into
	// its twin (0x78 -> 0x7C and so on) with the same meaning.
	localparam logic [7:0] OP_BLANK_CNT8  = 8'h78;
	localparam logic [7:0] OP_BLANK_CNT16 = 8'h79;
	localparam logic [7:0] OP_BYTE_CNT8   = 8'h7A;
	localparam logic [7:0] OP_BYTE_CNT16  = 8'h7B;
	localparam logic [7:0] OP_COPY_CNT8   = OP_HDR_COPY;
	localparam logic [7:0] OP_COPY_CNT16  = 8'hF9;
	localparam logic [7:0] OP_ALIAS       = 8'h04;

	localparam int DRAIN_CYCLES = 6;   // margin after the last awaited item
	localparam int HOLD_CYCLES  = 80;  // long receiver hold-off
	localparam int PRINT_CAP    = 40;

	typedef logic [7:0] byte_q_t[$];

	typedef struct {
		item_kind_t  kind;
		logic [7:0]  value;
		logic [16:0] length;
		logic [31:0] total;
		logic        done;
		end_status_t status;
	} decoded_t;

	logic        clk;
	logic        arst_n;
	logic        ceiling_we;
	logic [31:0] ceiling_wdata;

	prld_stream_if stream_ch ();
	prld_result_if result_ch ();

	pack_run_length_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.ceiling_we    (ceiling_we),
		.ceiling_wdata (ceiling_wdata),
		.stream        (stream_ch),
		.result        (result_ch)
	);

	// Decoder model state, a private copy of what the block keeps.
	phase_t      dec_phase;
	op_class_t   dec_class;
	logic [16:0] dec_pending;
	logic [7:0]  dec_count_hi;
	logic [31:0] dec_total;
	bit          dec_ended;
	logic [31:0] dec_ceiling;

	decoded_t awaited_items[$];
	int       mismatch_count = 0;
	int       items_sent = 0;
	int       idle_pct = 0;
	int       stall_pct = 0;
	int       hold_left = 0;
	logic     hold_req = 1'b0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Decoder model
	// ---------------------------------------------------------------------

	function automatic void clear_stream();
		dec_phase    = PH_OPCODE;
		dec_class    = CL_NONE;
		dec_pending  = '0;
		dec_count_hi = '0;
		dec_total    = '0;
		dec_ended    = 1'b0;
	endfunction

	// Fill one result item; any end status closes the stream.
	function automatic void close_item(output decoded_t r, input item_kind_t kind,
		input logic [7:0] value, input logic [16:0] length, input end_status_t status);
		r.kind   = kind;
		r.value  = value;
		r.length = length;
		r.total  = dec_total;
		r.done   = (status != ST_NONE);
		r.status = status;
		if (status != ST_NONE)
			dec_ended = 1'b1;
	endfunction

	function automatic bit within_ceiling(input logic [16:0] length);
		return ({1'b0, dec_total} + 33'(length)) <= {1'b0, dec_ceiling};
	endfunction

	// Emit a run descriptor, or end on overflow.
	function automatic bit emit_run(output decoded_t r, input logic [7:0] value,
		input logic [16:0] length, input bit last);
		if (!within_ceiling(length)) begin
			close_item(r, KIND_NONE, '0, '0, ST_OVERFLOW);
			return 1'b1;
		end
		dec_total += 32'(length);
		dec_phase = PH_OPCODE;
		close_item(r, KIND_RUN, value, length, last ? ST_EXHAUSTED : ST_NONE);
		return 1'b1;
	endfunction

	// Check the whole copy against the ceiling, then expect its literals.
	function automatic bit begin_copy(output decoded_t r, input logic [16:0] length,
		input bit last);
		if (!within_ceiling(length)) begin
			close_item(r, KIND_NONE, '0, '0, ST_OVERFLOW);
			return 1'b1;
		end
		dec_pending = length;
		dec_phase = PH_COPY;
		if (last) begin
			close_item(r, KIND_NONE, '0, '0, ST_EXHAUSTED);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic bit decode_opcode(output decoded_t r, input logic [7:0] op,
		input bit last);
		if (op <= OP_SHORT_MAX)
			return emit_run(r, BLANK_BYTE, 17'(op) + 17'd1, last);
		if (op >= OP_COPY_MIN && op <= OP_COPY_MAX)
			return begin_copy(r, 17'(op - OP_COPY_BIAS), last);
		if (op == OP_END_CLEAN) begin
			close_item(r, KIND_NONE, '0, '0, ST_CLEAN);
			return 1'b1;
		end
		if (op == OP_BAD_A || op == OP_BAD_B || op == OP_BAD_C) begin
			close_item(r, KIND_NONE, '0, '0, ST_MALFORMED);
			return 1'b1;
		end
		// Counted headers: bit 0 picks a two-byte count, bit 1 a run byte.
		if (op >= OP_HDR_COPY)
			dec_class = CL_COPY;
		else if (op[1])
			dec_class = CL_BYTE;
		else
			dec_class = CL_BLANK;
		dec_count_hi = '0;
		dec_phase = op[0] ? PH_COUNT_HI : PH_COUNT_LO;
		if (last) begin
			close_item(r, KIND_NONE, '0, '0, ST_EXHAUSTED);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Advance the model by one accepted byte; return 1 when it yields an item.
	function automatic bit decode_byte(input logic [7:0] b, input bit first, input bit last,
		output decoded_t r);
		logic [16:0] count;
		if (first)
			clear_stream();
		else if (dec_ended)
			return 1'b0;
		case (dec_phase)
			PH_COUNT_HI: begin
				dec_count_hi = b;
				dec_phase = PH_COUNT_LO;
				if (last) begin
					close_item(r, KIND_NONE, '0, '0, ST_EXHAUSTED);
					return 1'b1;
				end
				return 1'b0;
			end
			PH_COUNT_LO: begin
				count = {dec_count_hi, b} + 17'd1;
				dec_pending = count;
				if (dec_class == CL_BLANK)
					return emit_run(r, BLANK_BYTE, count, last);
				if (dec_class == CL_COPY)
					return begin_copy(r, count, last);
				dec_phase = PH_RUN_BYTE;
				if (last) begin
					close_item(r, KIND_NONE, '0, '0, ST_EXHAUSTED);
					return 1'b1;
				end
				return 1'b0;
			end
			PH_RUN_BYTE: return emit_run(r, b, dec_pending, last);
			PH_COPY: begin
				dec_total += 32'd1;
				dec_pending -= 17'd1;
				if (dec_pending == '0)
					dec_phase = PH_OPCODE;
				close_item(r, KIND_LIT, b, 17'd1, last ? ST_EXHAUSTED : ST_NONE);
				return 1'b1;
			end
			default: begin
				dec_phase = PH_OPCODE;
				return decode_opcode(r, b, last);
			end
		endcase
	endfunction

	// ---------------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------------

	task automatic report_mismatch(input string what, input logic [31:0] want,
		input logic [31:0] got);
		if (mismatch_count < PRINT_CAP)
			$display("mismatch %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
		mismatch_count++;
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_mismatch(what, want, got);
	endtask

	task automatic check_result();
		decoded_t want;
		if (awaited_items.size() == 0) begin
			report_mismatch("result with nothing awaited", '0, result_ch.total_out);
			return;
		end
		want = awaited_items.pop_front();
		check_field("item_kind", result_ch.item_kind, want.kind);
		check_field("out_byte", result_ch.out_byte, want.value);
		check_field("run_length", result_ch.run_length, want.length);
		check_field("total_out", result_ch.total_out, want.total);
		check_field("end_flag", result_ch.end_flag, want.done);
		check_field("end_status", result_ch.end_status, want.status);
	endtask

	// Check first, then predict: a result never stems from the byte taken at
	// the same edge, and all pre-edge values are read here.
	always @(posedge clk) begin
		decoded_t r;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready)
				check_result();
			if (stream_ch.valid && stream_ch.ready) begin
				if (decode_byte(stream_ch.data_byte, stream_ch.first_byte,
					stream_ch.last_byte, r))
					awaited_items.push_back(r);
			end
		end
	end

	// Receiver: random stalls, or a long hold-off counted down here on request.
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req <= 1'b0;
			hold_left <= HOLD_CYCLES;
			result_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------

	// Offer one item and hold it until taken; valid stays high between items
	// unless a random gap is drawn.
	task automatic send_byte(input logic [7:0] b, input bit first, input bit last);
		while ($urandom_range(0, 99) < idle_pct) begin
			stream_ch.valid <= 1'b0;
			@(posedge clk);
		end
		stream_ch.valid      <= 1'b1;
		stream_ch.data_byte  <= b;
		stream_ch.first_byte <= first;
		stream_ch.last_byte  <= last;
		do
			@(posedge clk);
		while (!stream_ch.ready);
		items_sent++;
	endtask

	task automatic send_stream(input byte_q_t s, input bit mark_last);
		foreach (s[i])
			send_byte(s[i], i == 0, mark_last && (i == s.size() - 1));
	endtask

	// Drop valid, wait for every awaited item, then let the pipeline empty.
	task automatic wait_drained();
		stream_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (awaited_items.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_ceiling(input logic [31:0] value);
		wait_drained();
		ceiling_we <= 1'b1;
		ceiling_wdata <= value;
		dec_ceiling = value;
		@(posedge clk);
		ceiling_we <= 1'b0;
	endtask

	function automatic logic [7:0] pick_alias();
		return $urandom_range(0, 1) ? OP_ALIAS : 8'h00;
	endfunction

	// Build one well-formed stream with random content and a random ending.
	function automatic void make_stream(output byte_q_t s, output bit mark_last);
		int n;
		int cut;
		s = {};
		mark_last = 1'b0;
		repeat ($urandom_range(1, 6)) begin
			case ($urandom_range(0, 9))
				0: s.push_back(8'($urandom_range(0, OP_SHORT_MAX)));
				1: begin
					s.push_back(OP_BLANK_CNT8 | pick_alias());
					s.push_back(8'($urandom));
				end
				2: begin
					s.push_back(OP_BLANK_CNT16 | pick_alias());
					s.push_back(8'($urandom));
					s.push_back(8'($urandom));
				end
				3: begin
					s.push_back(OP_BYTE_CNT8 | pick_alias());
					s.push_back(8'($urandom));
					s.push_back(8'($urandom));
				end
				4: begin
					s.push_back(OP_BYTE_CNT16 | pick_alias());
					s.push_back(8'($urandom));
					s.push_back(8'($urandom));
					s.push_back(8'($urandom));
				end
				5, 6: begin
					n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 120)
						: $urandom_range(1, 8);
					s.push_back(OP_COPY_BIAS + 8'(n));
					repeat (n) s.push_back(8'($urandom));
				end
				7: begin
					n = $urandom_range(0, 7);
					s.push_back(OP_COPY_CNT8 | pick_alias());
					s.push_back(8'(n));
					repeat (n + 1) s.push_back(8'($urandom));
				end
				8: begin
					n = $urandom_range(0, 5);
					s.push_back(OP_COPY_CNT16 | pick_alias());
					s.push_back(8'h00);
					s.push_back(8'(n));
					repeat (n + 1) s.push_back(8'($urandom));
				end
				default: s.push_back(8'($urandom));
			endcase
		end
		case ($urandom_range(0, 4))
			0, 1: begin
				if ($urandom_range(0, 1))
					s.push_back(OP_END_CLEAN);
				else
					case ($urandom_range(0, 2))
						0: s.push_back(OP_BAD_A);
						1: s.push_back(OP_BAD_B);
						default: s.push_back(OP_BAD_C);
					endcase
				// Trailing bytes after an end are ignored by the block.
				if ($urandom_range(0, 2) == 0)
					repeat ($urandom_range(1, 2)) s.push_back(8'($urandom));
				mark_last = 1'($urandom_range(0, 1));
			end
			2: mark_last = 1'b1;
			3: ;
			default: begin
				// Cut short anywhere, even inside a header or a copy.
				cut = $urandom_range(1, s.size());
				s = s[0:cut - 1];
				mark_last = 1'b1;
			end
		endcase
	endfunction

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Each run, copy and count-header family and the clean end, straight after reset
	// without a first mark; the byte after the clean end is ignored.
	task automatic test_opcodes();
		byte_q_t s;
		s = {8'h00, OP_SHORT_MAX,
			OP_BLANK_CNT8 | OP_ALIAS, 8'h05,
			OP_BLANK_CNT16, 8'hFF, 8'hFF,
			OP_BYTE_CNT8, 8'h02, 8'hAB,
			OP_BYTE_CNT16 | OP_ALIAS, 8'h01, 8'h00, 8'h55,
			OP_COPY_MIN, 8'h11,
			OP_COPY_CNT8 | OP_ALIAS, 8'h01, 8'hA5, 8'h5A,
			OP_COPY_CNT16, 8'h00, 8'h00, 8'hC3,
			OP_END_CLEAN, 8'h12};
		foreach (s[i])
			send_byte(s[i], 1'b0, 1'b0);
	endtask

	// Malformed and clean end codes; an end code beats the last mark.
	task automatic test_end_codes();
		byte_q_t s;
		s = {OP_BAD_A};
		send_stream(s, 1'b0);
		s = {OP_BAD_B, 8'h33};
		send_stream(s, 1'b0);
		s = {OP_BAD_C};
		send_stream(s, 1'b1);
		s = {8'h10, OP_END_CLEAN};
		send_stream(s, 1'b1);
	endtask

	// Last mark on each kind of unfinished or finishing byte.
	task automatic test_last_mark();
		byte_q_t s;
		s = {8'h20};
		send_stream(s, 1'b1);
		s = {OP_BYTE_CNT16};
		send_stream(s, 1'b1);
		s = {OP_BLANK_CNT16, 8'h12};
		send_stream(s, 1'b1);
		s = {OP_BYTE_CNT8, 8'h03};
		send_stream(s, 1'b1);
		s = {OP_COPY_CNT16, 8'h00, 8'h04, 8'hAA, 8'hBB};
		send_stream(s, 1'b1);
		s = {8'h85};
		send_stream(s, 1'b1);
		s = {OP_COPY_CNT8, 8'h00};
		send_stream(s, 1'b1);
	endtask

	// Overflow of runs and copies at a zero and a small ceiling, and after the
	// ceiling drops below what the stream already produced.
	task automatic test_ceiling();
		byte_q_t s;
		write_ceiling(32'd0);
		s = {8'h00};
		send_stream(s, 1'b0);
		s = {OP_COPY_MIN, 8'h01};
		send_stream(s, 1'b0);
		write_ceiling(32'd10);
		s = {8'h05, 8'h03, 8'h00};
		send_stream(s, 1'b0);
		s = {8'h81, 8'h11, 8'h22, OP_COPY_MAX};
		send_stream(s, 1'b0);
		write_ceiling(32'hFFFF_FFFF);
		s = {OP_BLANK_CNT16, 8'hFF, 8'hFF};
		send_stream(s, 1'b0);
		write_ceiling(32'd100);
		send_byte(8'h00, 1'b0, 1'b0);
	endtask

	// Hold the receiver off while a long copy streams in so the block backs
	// up, then pause the sender mid-copy until all is out and resume.
	task automatic test_long_stall();
		byte_q_t s;
		write_ceiling(CEILING_RESET);
		idle_pct = 0;
		stall_pct = 0;
		s = {OP_COPY_CNT16, 8'h00, 8'h3F};
		repeat (40) s.push_back(8'($urandom));
		hold_req <= 1'b1;
		send_stream(s, 1'b0);
		wait_drained();
		repeat (24) send_byte(8'($urandom), 1'b0, 1'b0);
		send_byte(OP_END_CLEAN, 1'b0, 1'b0);
	endtask

	task automatic test_random(input int idle, input int stall, input logic [31:0] ceiling,
		input int n_items);
		byte_q_t s;
		bit mark_last;
		int start;
		write_ceiling(ceiling);
		idle_pct = idle;
		stall_pct = stall;
		start = items_sent;
		while (items_sent - start < n_items) begin
			make_stream(s, mark_last);
			send_stream(s, mark_last);
		end
	endtask

	// ---------------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------------

	initial begin
		arst_n = 1'b0;
		ceiling_we = 1'b0;
		ceiling_wdata = '0;
		stream_ch.valid = 1'b0;
		stream_ch.data_byte = '0;
		stream_ch.first_byte = 1'b0;
		stream_ch.last_byte = 1'b0;
		result_ch.ready = 1'b0;
		clear_stream();
		dec_ceiling = CEILING_RESET;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_opcodes();
		test_end_codes();
		test_last_mark();
		test_ceiling();
		test_long_stall();
		test_random(0, 0, 32'hFFFF_FFFF, 70);
		test_random(78, 0, CEILING_RESET, 70);
		test_random(0, 78, 32'd3000, 70);
		test_random(18, 18, 32'($urandom_range(200, 70000)), 70);
		wait_drained();

		if (mismatch_count == 0)
			$display("PASS pack_run_length_decoder");
		else
			$display("FAIL pack_run_length_decoder");
		$finish;
	end

	// Stop a hung run; a correct one ends far sooner.
	initial begin
		#5_000_000;
		$display("FAIL pack_run_length_decoder");
		$finish;
	end

endmodule
